>>> hdl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the channel interfaces, the front, queue and back modules, and the top level.
// No dependencies.
package utf8d_pkg;

	localparam int unsigned CP_W       = 21;
	localparam int unsigned NB_W       = 3;
	localparam int unsigned LO_W       = 17;
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_UTF8_MODE    = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_UTF16_OUTPUT = 4'd1;

	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_FIRST  = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_LAST   = 21'h00DFFF;
	localparam logic [CP_W-1:0] SUPP_BASE   = 21'h010000;
	localparam logic [CP_W-1:0] HI_SURR     = 21'h00D800;
	localparam logic [CP_W-1:0] LO_SURR     = 21'h00DC00;

	localparam logic [LO_W-1:0] MIN_2BYTE   = 17'h00080;
	localparam logic [LO_W-1:0] MIN_3BYTE   = 17'h00800;
	localparam logic [LO_W-1:0] MIN_4BYTE   = 17'h10000;

	localparam logic [NB_W-1:0] LEN_NONE    = 3'd0;
	localparam logic [NB_W-1:0] LEN_1       = 3'd1;
	localparam logic [NB_W-1:0] LEN_2       = 3'd2;
	localparam logic [NB_W-1:0] LEN_3       = 3'd3;
	localparam logic [NB_W-1:0] LEN_4       = 3'd4;

	// one decoded item waiting between front and back
	typedef struct packed {
		logic            err;
		logic [CP_W-1:0] cp;
		logic [NB_W-1:0] nbytes;
	} q_entry_t;

endpackage

>>> hdl/utf8d_if.sv
// Valid/ready channel interfaces of the UTF-8 stream decoder: bytes in, units out, config writes.
// Depends on utf8d_pkg.
interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       drop_partial;

	modport source (output valid, in_byte, drop_partial, input ready);
	modport sink (input valid, in_byte, drop_partial, output ready);
endinterface

interface utf8d_out_if;
	logic                          valid;
	logic                          ready;
	logic [utf8d_pkg::CP_W-1:0]    code_unit;
	logic                          status;
	logic                          is_terminator;
	logic [utf8d_pkg::NB_W-1:0]    seq_bytes;
	logic                          last;

	modport source (output valid, code_unit, status, is_terminator, seq_bytes, last,
		input ready);
	modport sink (input valid, code_unit, status, is_terminator, seq_bytes, last,
		output ready);
endinterface

interface utf8d_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [utf8d_pkg::CFG_ADDR_W-1:0]  index;
	logic [utf8d_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/utf8d_front.sv
// Front of the decoder: accepts bytes, tracks the open sequence and classifies each byte.
// Pushes one queue entry per byte that yields a result. Depends on utf8d_pkg, utf8d_if.
module utf8d_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  utf8_mode,
	utf8d_in_if.sink              bytes,
	input  logic                  full,
	output logic                  push,
	output utf8d_pkg::q_entry_t   entry
);

	logic [utf8d_pkg::CP_W-1:0] pv_q, pv_d;
	logic [utf8d_pkg::NB_W-1:0] exp_q, exp_d;
	logic [utf8d_pkg::NB_W-1:0] seen_q, seen_d;
	logic [utf8d_pkg::LO_W-1:0] lo_q, lo_d;

	logic                       accept;
	logic                       produce;
	logic [7:0]                 b;
	logic [utf8d_pkg::CP_W-1:0] acc;
	logic [utf8d_pkg::NB_W-1:0] seen_inc;
	logic                       bad_value;

	assign bytes.ready = !full;
	assign accept      = bytes.valid && bytes.ready;
	assign push        = accept && produce;
	assign b           = bytes.in_byte;
	assign acc         = {pv_q[utf8d_pkg::CP_W-7:0], b[5:0]};
	assign seen_inc    = seen_q + 3'd1;
	assign bad_value   = (acc < {4'd0, lo_q}) || (acc > utf8d_pkg::CP_MAX)
		|| (acc >= utf8d_pkg::SURR_FIRST && acc <= utf8d_pkg::SURR_LAST);

	always_comb begin
		pv_d         = pv_q;
		exp_d        = exp_q;
		seen_d       = seen_q;
		lo_d         = lo_q;
		produce      = 1'b0;
		entry.err    = 1'b0;
		entry.cp     = {13'd0, b};
		entry.nbytes = utf8d_pkg::LEN_1;
		if (bytes.drop_partial) begin
			pv_d   = '0;
			exp_d  = utf8d_pkg::LEN_NONE;
			seen_d = '0;
			lo_d   = '0;
		end else if (!utf8_mode) begin
			produce = 1'b1;
		end else if (exp_q == utf8d_pkg::LEN_NONE) begin
			seen_d = utf8d_pkg::LEN_1;
			case (b) inside
				[8'h00:8'h7F]: begin
					produce = 1'b1;
					seen_d  = '0;
				end
				[8'hC2:8'hDF]: begin
					exp_d = utf8d_pkg::LEN_2;
					pv_d  = {16'd0, b[4:0]};
					lo_d  = utf8d_pkg::MIN_2BYTE;
				end
				[8'hE0:8'hEF]: begin
					exp_d = utf8d_pkg::LEN_3;
					pv_d  = {17'd0, b[3:0]};
					lo_d  = utf8d_pkg::MIN_3BYTE;
				end
				[8'hF0:8'hF4]: begin
					exp_d = utf8d_pkg::LEN_4;
					pv_d  = {18'd0, b[2:0]};
					lo_d  = utf8d_pkg::MIN_4BYTE;
				end
				default: begin
					// bad lead byte: reject it alone
					produce   = 1'b1;
					seen_d    = '0;
					entry.err = 1'b1;
					entry.cp  = '0;
				end
			endcase
		end else if (b[7:6] != 2'b10) begin
			produce      = 1'b1;
			entry.err    = 1'b1;
			entry.cp     = '0;
			entry.nbytes = seen_inc;
			pv_d         = '0;
			exp_d        = utf8d_pkg::LEN_NONE;
			seen_d       = '0;
			lo_d         = '0;
		end else if (seen_inc < exp_q) begin
			pv_d   = acc;
			seen_d = seen_inc;
		end else begin
			// sequence complete: check range, then close
			produce      = 1'b1;
			entry.err    = bad_value;
			entry.cp     = bad_value ? '0 : acc;
			entry.nbytes = seen_inc;
			pv_d         = '0;
			exp_d        = utf8d_pkg::LEN_NONE;
			seen_d       = '0;
			lo_d         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			exp_q  <= utf8d_pkg::LEN_NONE;
			seen_q <= '0;
			lo_q   <= '0;
		end else if (accept) begin
			pv_q   <= pv_d;
			exp_q  <= exp_d;
			seen_q <= seen_d;
			lo_q   <= lo_d;
		end
	end

endmodule

>>> hdl/utf8d_queue.sv
// Short FIFO of decoded entries between the front and the back of the decoder.
// Depends on utf8d_pkg.
module utf8d_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf8d_pkg::q_entry_t wr_entry,
	input  logic                pop,
	output utf8d_pkg::q_entry_t rd_entry,
	output logic                full,
	output logic                empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	utf8d_pkg::q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/utf8d_back.sv
// Back of the decoder: drains the queue into the output register, splitting
// supplementary code points into a surrogate pair when UTF-16 output is on. Depends on utf8d_pkg, utf8d_if.
module utf8d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                utf16_output,
	input  utf8d_pkg::q_entry_t head,
	input  logic                empty,
	output logic                pop,
	utf8d_out_if.source         units
);

	logic                       valid_q;
	logic [utf8d_pkg::CP_W-1:0] unit_q;
	logic                       err_q;
	logic                       term_q;
	logic [utf8d_pkg::NB_W-1:0] nb_q;
	logic                       last_q;
	logic                       pend_q;
	logic [9:0]                 pend_lo_q;

	logic                       load;
	logic                       split;
	logic [utf8d_pkg::CP_W-1:0] off;
	logic [utf8d_pkg::CP_W-1:0] hi_unit;
	logic [utf8d_pkg::CP_W-1:0] lo_unit;

	assign load    = !valid_q || units.ready;
	assign pop     = load && !pend_q && !empty;
	assign split   = !head.err && utf16_output && (head.cp >= utf8d_pkg::SUPP_BASE);
	assign off     = head.cp - utf8d_pkg::SUPP_BASE;
	assign hi_unit = utf8d_pkg::HI_SURR + {11'd0, off[19:10]};
	assign lo_unit = utf8d_pkg::LO_SURR + {11'd0, pend_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				pend_q  <= split;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				// low half of the pair; seq_bytes holds from the high half
				unit_q <= lo_unit;
				err_q  <= 1'b0;
				term_q <= 1'b0;
				last_q <= 1'b1;
			end else if (!empty) begin
				unit_q    <= split ? hi_unit : head.cp;
				err_q     <= head.err;
				term_q    <= !head.err && (head.cp == '0);
				nb_q      <= head.nbytes;
				last_q    <= !split;
				pend_lo_q <= off[9:0];
			end
		end
	end

	assign units.valid         = valid_q;
	assign units.code_unit     = unit_q;
	assign units.status        = err_q;
	assign units.is_terminator = term_q;
	assign units.seq_bytes     = nb_q;
	assign units.last          = last_q;

endmodule

>>> hdl/utf8_stream_decoder_top.sv
// Top level of the strict UTF-8 stream decoder: config registers, front, queue and back.
// Depends on utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue, utf8d_back.
//
//   channel  role   carries
//   -------  -----  ------------------------------------------------------------
//   bytes    sink   in_byte, drop_partial
//   units    source code_unit, status, is_terminator, seq_bytes, last
//   cfg      sink   index, data (utf8_mode at index 0, utf16_output at index 1)
//
// One byte per cycle is accepted while the queue has room; a byte's result is
// written into the queue when the byte is accepted and later loaded from the
// queue into the output register.
// A surrogate pair goes out high half first; no pop while the low half loads.
// A stalled output fills the QUEUE_DEPTH-entry queue, then bytes.ready drops.
// Reset clears the open sequence, the queue and the output; cfg is always ready.
module utf8_stream_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input logic         clk,
	input logic         arst_n,
	utf8d_in_if.sink    bytes,
	utf8d_out_if.source units,
	utf8d_cfg_if.sink   cfg
);

	logic                utf8_mode_q;
	logic                utf16_output_q;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	utf8d_pkg::q_entry_t wr_entry;
	utf8d_pkg::q_entry_t rd_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_mode_q    <= 1'b1;
			utf16_output_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			// only bit 0 counts; other indexes are dropped
			if (cfg.index == utf8d_pkg::CFG_UTF8_MODE) begin
				utf8_mode_q <= cfg.data[0];
			end else if (cfg.index == utf8d_pkg::CFG_UTF16_OUTPUT) begin
				utf16_output_q <= cfg.data[0];
			end
		end
	end

	utf8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.utf8_mode (utf8_mode_q),
		.bytes     (bytes),
		.full      (full),
		.push      (push),
		.entry     (wr_entry)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (empty)
	);

	utf8d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.utf16_output (utf16_output_q),
		.head         (rd_entry),
		.empty        (empty),
		.pop          (pop),
		.units        (units)
	);

	// a high surrogate taken is followed at once by its low half
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && units.ready && !units.last |=> units.valid && units.last)
		else $error("low surrogate did not follow high surrogate");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && units.status |->
			units.code_unit == '0 && !units.is_terminator && units.last)
		else $error("error result carries a nonzero unit");

	a_high_range: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && !units.last |->
			units.code_unit >= 21'h00D800 && units.code_unit <= 21'h00DBFF && !units.status)
		else $error("non-final result is not a high surrogate");

	a_pair_only_utf16: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && !units.last |-> utf16_output_q && utf8_mode_q)
		else $error("surrogate split outside UTF-16 decoding");

endmodule
